FILE: sv/sslp_pkg.sv
package sslp_pkg;

  localparam int PFX_LEN = 7;
  localparam int RDY_LEN = 22;
  localparam int NUM_CAP = 100000;
  localparam int ACC_W   = 17;
  localparam int FLD_W   = 5;
  localparam int TOK_W   = 3;

  localparam logic [PFX_LEN*8-1:0] PFX_ICP = "$BDICP,";
  localparam logic [PFX_LEN*8-1:0] PFX_PWI = "$BDPWI,";
  localparam logic [PFX_LEN*8-1:0] PFX_FKI = "$BDFKI,";
  localparam logic [RDY_LEN*8-1:0] RDY_TXT = "READY FOR TRANSMISSION";
  localparam logic [23:0]          CMD_TCQ = "TCQ";

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  localparam logic FUNC_RX  = 1'b0;
  localparam logic FUNC_CLR = 1'b1;

  localparam logic [1:0] ACK_NONE = 2'd0;
  localparam logic [1:0] ACK_PASS = 2'd1;
  localparam logic [1:0] ACK_FAIL = 2'd2;

  // token slots of the two sentence grammars
  localparam logic [TOK_W-1:0] TOK_CMD      = 3'd1;
  localparam logic [TOK_W-1:0] TOK_VALID    = 3'd2;
  localparam logic [TOK_W-1:0] TOK_SIG1     = 3'd4;
  localparam logic [TOK_W-1:0] TOK_PWI_LAST = 3'd5;
  localparam logic [TOK_W-1:0] TOK_FKI_LAST = 3'd3;
  localparam logic [TOK_W-1:0] TOK_CODE     = 3'd3;

  localparam logic [FLD_W-1:0] UTC_MAX = 5'd31;
  localparam logic [FLD_W-1:0] CMD_MAX = 5'd15;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } ctrl_state_e;

  typedef enum logic [7:0] {
    PH_FLD  = 8'b0000_0001,
    PH_YN   = 8'b0000_0010,
    PH_CM   = 8'b0000_0100,
    PH_SP   = 8'b0000_1000,
    PH_SG   = 8'b0001_0000,
    PH_DG   = 8'b0010_0000,
    PH_DONE = 8'b0100_0000,
    PH_FAIL = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic load;
    logic exec;
  } sslp_cmd_t;

  function automatic logic [7:0] pfx_char(input logic [PFX_LEN*8-1:0] txt,
                                          input logic [2:0] idx);
    int sh;
    sh = (PFX_LEN - 1 - int'(idx)) * 8;
    return txt[sh +: 8];
  endfunction

endpackage

FILE: sv/status_sentence_line_parser.sv
// The result beat is valid in the output state, reached through the step
// state once the input beat is accepted. The controller holds each item
// through a capture, a parse step and a result hold that lasts while the
// output is stalled. Sentences are parsed on the fly as bytes arrive, so a
// line feed costs no more than any other byte. Reset is asynchronous, active
// low, and brings the status to its cleared values (code reads -1).
module status_sentence_line_parser
  import sslp_pkg::*;
#(
  parameter int LINE_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               line_done_o,
  output logic               ready_flag_o,
  output logic               link_valid_o,
  output logic [15:0]        signal_level_o,
  output logic [15:0]        ack_count_o,
  output logic [1:0]         ack_outcome_o,
  output logic signed [15:0] ack_code_o
);

  sslp_cmd_t cmd;

  // sequencer: one beat in flight at a time
  sslp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // line tracking, prefix/phrase match, field parser and status registers
  sslp_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .rx_byte_i      (rx_byte_i),
    .line_done_o    (line_done_o),
    .ready_flag_o   (ready_flag_o),
    .link_valid_o   (link_valid_o),
    .signal_level_o (signal_level_o),
    .ack_count_o    (ack_count_o),
    .ack_outcome_o  (ack_outcome_o),
    .ack_code_o     (ack_code_o)
  );

endmodule

FILE: sv/sslp_ctrl.sv
module sslp_ctrl
  import sslp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sslp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_OUT;
      ST_OUT:  if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign cmd_o.load  = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.exec  = (state_q == ST_EXEC);

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state not one-hot");
  a_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("step not followed by result");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
`endif

endmodule

FILE: sv/sslp_dp.sv
module sslp_dp
  import sslp_pkg::*;
#(
  parameter int LINE_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sslp_cmd_t          cmd_i,
  input  logic               func_i,
  input  logic [7:0]         rx_byte_i,
  output logic               line_done_o,
  output logic               ready_flag_o,
  output logic               link_valid_o,
  output logic [15:0]        signal_level_o,
  output logic [15:0]        ack_count_o,
  output logic [1:0]         ack_outcome_o,
  output logic signed [15:0] ack_code_o
);

  localparam int LW = $clog2(LINE_BYTES);

  logic             func_q;
  logic [7:0]       byte_q;
  logic [LW-1:0]    len_q, len_d;
  logic [7:0]       hist_q [RDY_LEN-1];
  logic             icp_q, icp_d, pwi_q, pwi_d, fki_q, fki_d, rdy_q, rdy_d;
  phase_e           phase_q, phase_d;
  logic [TOK_W-1:0] tok_q, tok_d;
  logic [FLD_W-1:0] k_q, k_d;
  logic             cmatch_q, cmatch_d, tcq_q, tcq_d, v1_q, v1_d, s1pos_q, s1pos_d;
  logic [15:0]      s1val_q, s1val_d;
  logic [7:0]       yn_q, yn_d;
  logic             neg_q, neg_d;
  logic [ACC_W-1:0] acc_q, acc_d;

  logic             done_q, done_d, rdy_st_q, rdy_st_d, val_q, val_d;
  logic [15:0]      sig_q, sig_d, cnt_q, cnt_d;
  logic [1:0]       out_q, out_d;
  logic [15:0]      code_q, code_d;

  logic is_prn, is_dig, full, store, eol, ovf, in_pfx, past_pfx, prs_on, last_tok, win_hit;
  logic lim, ok_end;
  logic [3:0]       dig;
  logic [20:0]      acc_wide;
  logic [ACC_W-1:0] acc_nx;
  logic [15:0]      acc_sat;
  logic signed [17:0] code_full;
  logic [15:0]      code_sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      byte_q <= rx_byte_i;
    end
    if (store) begin
      hist_q[0] <= byte_q;
      for (int i = 1; i < RDY_LEN - 1; i++) hist_q[i] <= hist_q[i-1];
    end
  end

  assign is_prn   = (byte_q >= PRINT_LO) && (byte_q <= PRINT_HI);
  assign is_dig   = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign dig      = 4'(byte_q - CH_ZERO);
  assign full     = (len_q == LW'(LINE_BYTES - 1));
  assign store    = cmd_i.exec && (func_q == FUNC_RX) && is_prn && !full;
  assign ovf      = cmd_i.exec && (func_q == FUNC_RX) && is_prn && full;
  assign eol      = cmd_i.exec && (func_q == FUNC_RX) && (byte_q == CH_LF);
  assign in_pfx   = (len_q < LW'(PFX_LEN));
  assign past_pfx = !in_pfx;
  assign prs_on   = store && past_pfx && (pwi_q || fki_q);
  assign last_tok = pwi_q ? (tok_q == TOK_PWI_LAST) : (tok_q == TOK_FKI_LAST);
  assign lim      = pwi_q ? (k_q == UTC_MAX) : ((tok_q == TOK_CMD) && (k_q == CMD_MAX));

  // decimal accumulate with magnitude cap
  assign acc_wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {17'd0, dig};
  assign acc_nx   = (acc_wide > 21'(NUM_CAP)) ? ACC_W'(NUM_CAP) : acc_wide[ACC_W-1:0];
  assign acc_sat  = (acc_q > 17'd65535) ? 16'hFFFF : acc_q[15:0];
  assign code_full = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
  assign code_sat = (code_full > 18'sd32767)  ? 16'h7FFF :
                    (code_full < -18'sd32768) ? 16'h8000 : code_full[15:0];

  // phrase match over the last bytes of the line
  always_comb begin
    win_hit = (len_q >= LW'(RDY_LEN - 1)) && (byte_q == RDY_TXT[7:0]);
    for (int j = 0; j < RDY_LEN - 1; j++) begin
      if (hist_q[RDY_LEN-2-j] != RDY_TXT[(RDY_LEN-1-j)*8 +: 8]) win_hit = 1'b0;
    end
  end

  assign ok_end = (phase_q == PH_DONE) || ((phase_q == PH_DG) && last_tok);

  always_comb begin
    len_d = len_q; icp_d = icp_q; pwi_d = pwi_q; fki_d = fki_q; rdy_d = rdy_q;
    phase_d = phase_q; tok_d = tok_q; k_d = k_q; cmatch_d = cmatch_q; tcq_d = tcq_q;
    v1_d = v1_q; s1pos_d = s1pos_q; s1val_d = s1val_q; yn_d = yn_q;
    neg_d = neg_q; acc_d = acc_q;
    done_d = done_q; rdy_st_d = rdy_st_q; val_d = val_q; sig_d = sig_q;
    cnt_d = cnt_q; out_d = out_q; code_d = code_q;

    if (store) begin
      len_d = len_q + LW'(1);
      if (in_pfx) begin
        if (byte_q != pfx_char(PFX_ICP, len_q[2:0])) icp_d = 1'b0;
        if (byte_q != pfx_char(PFX_PWI, len_q[2:0])) pwi_d = 1'b0;
        if (byte_q != pfx_char(PFX_FKI, len_q[2:0])) fki_d = 1'b0;
      end
      if (win_hit) rdy_d = 1'b1;
    end

    if (prs_on) begin
      unique case (phase_q)
        PH_FLD: begin
          if (byte_q == CH_COMMA) begin
            if (k_q == '0) begin
              phase_d = PH_FAIL;
            end else if (pwi_q) begin
              tok_d = tok_q + TOK_W'(1); phase_d = PH_SP;
            end else if (tok_q == TOK_CMD) begin
              tcq_d = (k_q == 5'd3) && cmatch_q;
              tok_d = tok_q + TOK_W'(1); phase_d = PH_YN;
            end else begin
              tok_d = TOK_CMD; k_d = '0; cmatch_d = 1'b1;
            end
          end else if (lim) begin
            phase_d = PH_FAIL;
          end else begin
            k_d = (k_q == '1) ? k_q : k_q + FLD_W'(1);
            if (fki_q && (tok_q == TOK_CMD)) begin
              cmatch_d = cmatch_q && (k_q < 5'd3) &&
                         (byte_q == CMD_TCQ[(2 - int'(k_q[1:0])) * 8 +: 8]);
            end
          end
        end
        PH_YN: begin
          yn_d = byte_q; phase_d = PH_CM;
        end
        PH_CM: begin
          if (byte_q == CH_COMMA) begin
            tok_d = TOK_CODE; phase_d = PH_SP;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_SP: begin
          if (byte_q == CH_SPACE) begin
            phase_d = PH_SP;
          end else if ((byte_q == CH_PLUS) || (byte_q == CH_MINUS)) begin
            neg_d = (byte_q == CH_MINUS); phase_d = PH_SG;
          end else if (is_dig) begin
            neg_d = 1'b0; acc_d = ACC_W'(dig); phase_d = PH_DG;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_SG: begin
          if (is_dig) begin
            acc_d = ACC_W'(dig); phase_d = PH_DG;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_DG: begin
          if (is_dig) begin
            acc_d = acc_nx;
          end else if (last_tok) begin
            phase_d = PH_DONE;
          end else if (byte_q == CH_COMMA) begin
            if (tok_q == TOK_VALID) v1_d = !neg_q && (acc_q == 17'd1);
            if (tok_q == TOK_SIG1) begin
              s1pos_d = !neg_q && (acc_q != '0);
              s1val_d = acc_sat;
            end
            tok_d = tok_q + TOK_W'(1); phase_d = PH_SP;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_DONE: phase_d = PH_DONE;
        PH_FAIL: phase_d = PH_FAIL;
        default: phase_d = PH_FAIL;
      endcase
    end

    if (cmd_i.exec) done_d = 1'b0;

    if (eol && (len_q != '0)) begin
      done_d = 1'b1;
      if (rdy_q || (icp_q && past_pfx)) begin
        rdy_st_d = 1'b1;
      end else if (pwi_q && past_pfx) begin
        if (ok_end && v1_q && s1pos_q && !neg_q && (acc_q != '0)) begin
          val_d = 1'b1; sig_d = s1val_q;
        end else begin
          val_d = 1'b0; sig_d = '0;
        end
      end else if (fki_q && past_pfx) begin
        if (ok_end && tcq_q) begin
          cnt_d  = cnt_q + 16'd1;
          code_d = code_sat;
          out_d  = ((yn_q == CH_Y) && (acc_q == '0)) ? ACK_PASS : ACK_FAIL;
        end
      end
    end

    if (eol || ovf) begin
      len_d = '0; icp_d = 1'b1; pwi_d = 1'b1; fki_d = 1'b1; rdy_d = 1'b0;
      phase_d = PH_FLD; tok_d = '0; k_d = '0; cmatch_d = 1'b1; tcq_d = 1'b0;
      v1_d = 1'b0; s1pos_d = 1'b0; neg_d = 1'b0; acc_d = '0;
    end

    if (cmd_i.exec && (func_q == FUNC_CLR)) begin
      rdy_st_d = 1'b0; val_d = 1'b0; sig_d = '0; cnt_d = '0;
      out_d = ACK_NONE; code_d = 16'hFFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; icp_q <= 1'b1; pwi_q <= 1'b1; fki_q <= 1'b1; rdy_q <= 1'b0;
      phase_q <= PH_FLD; tok_q <= '0; k_q <= '0; cmatch_q <= 1'b1; tcq_q <= 1'b0;
      v1_q <= 1'b0; s1pos_q <= 1'b0; s1val_q <= '0; yn_q <= '0;
      neg_q <= 1'b0; acc_q <= '0;
      done_q <= 1'b0; rdy_st_q <= 1'b0; val_q <= 1'b0; sig_q <= '0;
      cnt_q <= '0; out_q <= ACK_NONE; code_q <= 16'hFFFF;
    end else begin
      len_q <= len_d; icp_q <= icp_d; pwi_q <= pwi_d; fki_q <= fki_d; rdy_q <= rdy_d;
      phase_q <= phase_d; tok_q <= tok_d; k_q <= k_d; cmatch_q <= cmatch_d;
      tcq_q <= tcq_d; v1_q <= v1_d; s1pos_q <= s1pos_d; s1val_q <= s1val_d;
      yn_q <= yn_d; neg_q <= neg_d; acc_q <= acc_d;
      done_q <= done_d; rdy_st_q <= rdy_st_d; val_q <= val_d; sig_q <= sig_d;
      cnt_q <= cnt_d; out_q <= out_d; code_q <= code_d;
    end
  end

  assign line_done_o    = done_q;
  assign ready_flag_o   = rdy_st_q;
  assign link_valid_o   = val_q;
  assign signal_level_o = sig_q;
  assign ack_count_o    = cnt_q;
  assign ack_outcome_o  = out_q;
  assign ack_code_o     = $signed(code_q);

`ifndef NO_ASSERTIONS
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(LINE_BYTES - 1))
    else $error("line length beyond store");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (func_q == FUNC_CLR)) |=> (cnt_q == '0) && (code_q == 16'hFFFF))
    else $error("clear did not reset status");
  a_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_q != 2'd3) && !(link_valid_o && (sig_q == '0)))
    else $error("status inconsistent");
`endif

endmodule
